/* rtl/core/tgn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tgn_pkg
// Shared types, constants and codes of the torus gather node.
// ----------------------------------------------------------------------------
package tgn_pkg;

   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int RANK_W     = 8;
   localparam int GEO_W      = 5;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int CNT_W      = 9;
   localparam int HOP_W      = 5;
   localparam int PBYTES_W   = 16;
   localparam int BYTES_W    = 24;
   localparam int PROD_W     = PBYTES_W + CNT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_CNT_W  = $clog2(RANK_W);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_RANK      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_RANK      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AGGREGATE_MODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_BYTES  = 3'd5;

   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_SEND     = 2'd1,
      ACT_COMPLETE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      PORT_NORTH = 2'd0,
      PORT_SOUTH = 2'd1,
      PORT_EAST  = 2'd2,
      PORT_WEST  = 2'd3
   } port_type;

   typedef enum logic {
      KIND_START  = 1'b0,
      KIND_ARRIVE = 1'b1
   } kind_type;

   typedef struct packed {
      logic                kind;
      logic [RANK_W-1:0]   dest_rank;
      logic [RANK_W-1:0]   source_rank;
      logic [CNT_W-1:0]    payload_count;
      logic [HOP_W-1:0]    hop_count;
   } req_type;

   typedef struct packed {
      logic [1:0]          action;
      logic [1:0]          out_port;
      logic [RANK_W-1:0]   out_dest_rank;
      logic [RANK_W-1:0]   out_source_rank;
      logic [CNT_W-1:0]    out_payload_count;
      logic [HOP_W-1:0]    out_hop_count;
      logic [BYTES_W-1:0]  byte_length;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DIV_START,
      OP_DIV_STORE,
      OP_DECIDE,
      OP_ROUTE,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      SEL_NODE_COL,
      SEL_NODE_ROW,
      SEL_ROOT_COL,
      SEL_DEST_COL,
      SEL_DEST_ROW
   } dsel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ROUTE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic     accept_en;
      op_type   op;
      dsel_type sel;
   } cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic req_fire;
      logic div_done;
      logic emit;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/tgn_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tgn_if
// Valid/ready channels of the torus gather node: request, response, csr.
// ----------------------------------------------------------------------------
interface tgn_req_if;
   import tgn_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tgn_rsp_if;
   import tgn_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tgn_csr_if;
   import tgn_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tgn_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tgn_div
// Restoring divider, one quotient bit per cycle, rank by geometry count.
// ----------------------------------------------------------------------------
module tgn_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tgn_pkg::RANK_W-1:0] dividend,
   input  wire logic [tgn_pkg::GEO_W-1:0]  divisor,
   output logic                            done,
   output logic [tgn_pkg::RANK_W-1:0]      quotient,
   output logic [tgn_pkg::GEO_W-1:0]       remainder
);
   import tgn_pkg::*;

   logic [RANK_W-1:0]    quo_ff, quo_in;
   logic [GEO_W-1:0]     rem_ff, rem_in;
   logic [GEO_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [GEO_W:0]       trial;
   logic [GEO_W:0]       diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[RANK_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[RANK_W-2:0], ge};
         rem_in = ge ? diff[GEO_W-1:0] : trial[GEO_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(RANK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/core/tgn_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tgn_dpath
// Datapath: config registers, node geometry, gather counters, routing and
// the response register.
// ----------------------------------------------------------------------------
module tgn_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tgn_req_if.sink                   req_if,
   tgn_rsp_if.source                 rsp_if,
   tgn_csr_if.sink                   csr_if,
   input  wire tgn_pkg::cmd_type     cmd,
   output tgn_pkg::status_type       status
);
   import tgn_pkg::*;

   // config
   logic [RANK_W-1:0]   node_ff, root_ff;
   logic [GEO_W-1:0]    rows_ff, cols_ff;
   logic                mode_ff;
   logic [PBYTES_W-1:0] pbytes_ff;
   logic [GEO_W-1:0]    geo_rows, geo_cols;
   logic [CNT_W-1:0]    nodes_m1;
   logic                cfg_wr;

   // geometry
   logic [COL_W-1:0]    cn_ff, cr_ff, dc_ff;
   logic [ROW_W-1:0]    mr_ff, dr_ff;
   logic [RANK_W-1:0]   qn_ff, qd_ff;

   // item
   req_type             in_ff;
   logic                req_fire;

   // gather state
   logic [CNT_W-1:0]    row_cnt_ff, root_cnt_ff;
   logic                sent_ff;

   // decision
   logic                emit_ff;
   logic [1:0]          act_ff;
   logic [RANK_W-1:0]   tgt_dest_ff, tgt_src_ff;
   logic [CNT_W-1:0]    tgt_pc_ff;
   logic [HOP_W-1:0]    tgt_hop_ff;
   logic                dec_emit, dec_complete, agg_try;
   logic [RANK_W-1:0]   dec_dest, dec_src;
   logic [CNT_W-1:0]    dec_pc, row_new, root_new, agg_total;
   logic [HOP_W-1:0]    dec_hop;
   logic                sent_new;
   logic                is_root, is_leader;
   logic [RANK_W:0]     leader_sum;

   // route
   logic [1:0]          port_ff, port_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [GEO_W-1:0]    d_fwd, d_bwd;

   // divider
   logic                div_start;
   logic [RANK_W-1:0]   div_dividend;
   logic [GEO_W-1:0]    div_divisor;
   logic                div_done;
   logic [RANK_W-1:0]   div_quo;
   logic [GEO_W-1:0]    div_rem;

   // response
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   function automatic logic [CNT_W-1:0] sat9(input logic [CNT_W:0] v);
      return v[CNT_W] ? {CNT_W{1'b1}} : v[CNT_W-1:0];
   endfunction

   // (a - b) mod n with a, b < n
   function automatic logic [GEO_W-1:0] ring_dist(input logic [COL_W-1:0] a,
                                                  input logic [COL_W-1:0] b,
                                                  input logic [GEO_W-1:0] n);
      logic [GEO_W:0] s;
      s = {2'b00, a} + {1'b0, n} - {2'b00, b};
      if (s >= {1'b0, n}) begin
         s = s - {1'b0, n};
      end
      return s[GEO_W-1:0];
   endfunction

   // config port
   assign csr_if.ready = 1'b1;
   assign cfg_wr       = csr_if.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff   <= '0;
         rows_ff   <= GEO_W'(4);
         cols_ff   <= GEO_W'(4);
         root_ff   <= '0;
         mode_ff   <= 1'b0;
         pbytes_ff <= PBYTES_W'(1024);
      end else if (cfg_wr) begin
         case (csr_if.index)
            CSR_NODE_RANK:      node_ff   <= csr_if.data[RANK_W-1:0];
            CSR_NUM_ROWS:       rows_ff   <= csr_if.data[GEO_W-1:0];
            CSR_NUM_COLS:       cols_ff   <= csr_if.data[GEO_W-1:0];
            CSR_ROOT_RANK:      root_ff   <= csr_if.data[RANK_W-1:0];
            CSR_AGGREGATE_MODE: mode_ff   <= csr_if.data[0];
            CSR_PAYLOAD_BYTES:  pbytes_ff <= csr_if.data[PBYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamped geometry
   always_comb begin
      geo_rows = rows_ff;
      if (rows_ff == '0) begin
         geo_rows = GEO_W'(1);
      end else if (rows_ff > GEO_W'(MAX_ROWS)) begin
         geo_rows = GEO_W'(MAX_ROWS);
      end
      geo_cols = cols_ff;
      if (cols_ff == '0) begin
         geo_cols = GEO_W'(1);
      end else if (cols_ff > GEO_W'(MAX_COLS)) begin
         geo_cols = GEO_W'(MAX_COLS);
      end
      nodes_m1 = ({{(CNT_W-GEO_W){1'b0}}, geo_rows} * {{(CNT_W-GEO_W){1'b0}}, geo_cols})
                 - 1'b1;
   end

   // input capture
   assign req_if.ready = cmd.accept_en;
   assign req_fire     = req_if.valid && cmd.accept_en;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_if.payload;
      end
   end

   // shared divider
   always_comb begin
      div_start    = cmd.op == OP_DIV_START;
      div_dividend = node_ff;
      div_divisor  = geo_cols;
      case (cmd.sel)
         SEL_NODE_COL: begin
            div_dividend = node_ff;
            div_divisor  = geo_cols;
         end
         SEL_NODE_ROW: begin
            div_dividend = qn_ff;
            div_divisor  = geo_rows;
         end
         SEL_ROOT_COL: begin
            div_dividend = root_ff;
            div_divisor  = geo_cols;
         end
         SEL_DEST_COL: begin
            div_dividend = tgt_dest_ff;
            div_divisor  = geo_cols;
         end
         SEL_DEST_ROW: begin
            div_dividend = qd_ff;
            div_divisor  = geo_rows;
         end
         default: begin
            div_dividend = node_ff;
            div_divisor  = geo_cols;
         end
      endcase
   end

   tgn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIV_STORE) begin
         case (cmd.sel)
            SEL_NODE_COL: begin
               cn_ff <= div_rem[COL_W-1:0];
               qn_ff <= div_quo;
            end
            SEL_NODE_ROW: mr_ff <= div_rem[ROW_W-1:0];
            SEL_ROOT_COL: cr_ff <= div_rem[COL_W-1:0];
            SEL_DEST_COL: begin
               dc_ff <= div_rem[COL_W-1:0];
               qd_ff <= div_quo;
            end
            SEL_DEST_ROW: dr_ff <= div_rem[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // gather decision
   always_comb begin
      is_root      = node_ff == root_ff;
      is_leader    = cn_ff == cr_ff;
      leader_sum   = {1'b0, node_ff} - {{(RANK_W-COL_W+1){1'b0}}, cn_ff}
                     + {{(RANK_W-COL_W+1){1'b0}}, cr_ff};
      dec_emit     = 1'b0;
      dec_complete = 1'b0;
      agg_try      = 1'b0;
      dec_dest     = root_ff;
      dec_src      = node_ff;
      dec_pc       = CNT_W'(1);
      dec_hop      = '0;
      row_new      = row_cnt_ff;
      root_new     = root_cnt_ff;
      sent_new     = sent_ff;
      if (in_ff.kind == KIND_START) begin
         if (!is_root) begin
            if (mode_ff) begin
               if (is_leader) begin
                  agg_try = 1'b1;
               end else begin
                  dec_emit = 1'b1;
                  dec_dest = leader_sum[RANK_W-1:0];
               end
            end else begin
               dec_emit = 1'b1;
            end
         end
      end else if (in_ff.dest_rank != node_ff) begin
         dec_emit = 1'b1;
         dec_dest = in_ff.dest_rank;
         dec_src  = in_ff.source_rank;
         dec_pc   = in_ff.payload_count;
         dec_hop  = in_ff.hop_count;
      end else if (is_root) begin
         root_new     = sat9({1'b0, root_cnt_ff} + {1'b0, in_ff.payload_count});
         dec_complete = root_new == nodes_m1;
      end else begin
         row_new = sat9({1'b0, row_cnt_ff} + {1'b0, in_ff.payload_count});
         agg_try = 1'b1;
      end
      agg_total = sat9({1'b0, row_new} + CNT_W'(1));
      if (agg_try && mode_ff && !sent_ff && !is_root && is_leader
          && agg_total >= CNT_W'(geo_cols)) begin
         dec_emit = 1'b1;
         dec_dest = root_ff;
         dec_src  = node_ff;
         dec_pc   = agg_total;
         dec_hop  = '0;
         sent_new = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff  <= '0;
         root_cnt_ff <= '0;
         sent_ff     <= 1'b0;
      end else if (cmd.op == OP_DECIDE) begin
         row_cnt_ff  <= row_new;
         root_cnt_ff <= root_new;
         sent_ff     <= sent_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DECIDE) begin
         emit_ff     <= dec_emit;
         act_ff      <= dec_emit ? ACT_SEND : (dec_complete ? ACT_COMPLETE : ACT_NONE);
         tgt_dest_ff <= dec_dest;
         tgt_src_ff  <= dec_src;
         tgt_pc_ff   <= dec_pc;
         tgt_hop_ff  <= dec_hop;
      end
   end

   // column first, then row, shorter way round
   always_comb begin
      port_in = PORT_EAST;
      d_fwd   = '0;
      d_bwd   = '0;
      if (dc_ff != cn_ff) begin
         d_fwd   = ring_dist(dc_ff, cn_ff, geo_cols);
         d_bwd   = ring_dist(cn_ff, dc_ff, geo_cols);
         port_in = (d_fwd <= d_bwd) ? PORT_EAST : PORT_WEST;
      end else if (dr_ff != mr_ff) begin
         d_fwd   = ring_dist(dr_ff, mr_ff, geo_rows);
         d_bwd   = ring_dist(mr_ff, dr_ff, geo_rows);
         port_in = (d_fwd <= d_bwd) ? PORT_SOUTH : PORT_NORTH;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ROUTE) begin
         port_ff <= port_in;
         prod_ff <= pbytes_ff * tgt_pc_ff;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.action = act_ff;
      if (emit_ff) begin
         rsp_in.out_port          = port_ff;
         rsp_in.out_dest_rank     = tgt_dest_ff;
         rsp_in.out_source_rank   = tgt_src_ff;
         rsp_in.out_payload_count = tgt_pc_ff;
         rsp_in.out_hop_count     = (tgt_hop_ff == {HOP_W{1'b1}}) ? tgt_hop_ff
                                    : tgt_hop_ff + 1'b1;
         rsp_in.byte_length       = (prod_ff > PROD_W'({BYTES_W{1'b1}}))
                                    ? {BYTES_W{1'b1}} : prod_ff[BYTES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   always_comb begin
      status.cfg_wr   = cfg_wr;
      status.req_fire = req_fire;
      status.div_done = div_done;
      status.emit     = dec_emit;
      status.out_busy = rsp_valid_ff && !rsp_if.ready;
   end

endmodule

`default_nettype wire

/* rtl/core/tgn_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tgn_ctrl
// Controller: geometry refresh after config writes and per-item sequencing.
// ----------------------------------------------------------------------------
module tgn_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tgn_pkg::status_type  status,
   output tgn_pkg::cmd_type          cmd
);
   import tgn_pkg::*;

   state_type state_ff, state_in;
   dsel_type  sel_ff, sel_in;
   logic      geo_ok_ff, geo_ok_in;
   logic      geo_dirty_ff, geo_dirty_in;
   logic      geo_set;
   logic      geo_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_NODE_COL;
         geo_ok_ff    <= 1'b0;
         geo_dirty_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         geo_ok_ff    <= geo_ok_in;
         geo_dirty_ff <= geo_dirty_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      geo_set       = 1'b0;
      geo_start     = 1'b0;
      cmd.accept_en = 1'b0;
      cmd.op        = OP_NONE;
      cmd.sel       = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!geo_ok_ff) begin
               geo_start = 1'b1;
               sel_in    = SEL_NODE_COL;
               state_in  = ST_DIV_START;
            end else begin
               cmd.accept_en = 1'b1;
               if (status.req_fire) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            cmd.op = OP_DECIDE;
            if (status.emit) begin
               sel_in   = SEL_DEST_COL;
               state_in = ST_DIV_START;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_DIV_START: begin
            cmd.op   = OP_DIV_START;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.op = OP_DIV_STORE;
               case (sel_ff)
                  SEL_NODE_COL: begin
                     sel_in   = SEL_NODE_ROW;
                     state_in = ST_DIV_START;
                  end
                  SEL_NODE_ROW: begin
                     sel_in   = SEL_ROOT_COL;
                     state_in = ST_DIV_START;
                  end
                  SEL_ROOT_COL: begin
                     geo_set  = 1'b1;
                     state_in = ST_IDLE;
                  end
                  SEL_DEST_COL: begin
                     sel_in   = SEL_DEST_ROW;
                     state_in = ST_DIV_START;
                  end
                  SEL_DEST_ROW: begin
                     state_in = ST_ROUTE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ROUTE: begin
            cmd.op   = OP_ROUTE;
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!status.out_busy) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a write forces a fresh geometry pass, also when it lands inside one
      geo_dirty_in = status.cfg_wr ? 1'b1 : (geo_start ? 1'b0 : geo_dirty_ff);
      geo_ok_in    = status.cfg_wr ? 1'b0
                     : ((geo_set && !geo_dirty_ff) ? 1'b1 : geo_ok_ff);
   end

endmodule

`default_nettype wire

/* rtl/core/torus_gather_node_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// torus_gather_node_unit
// One node of a 2D torus gather network with dimension-order forwarding.
//
// req_if takes start or packet-arrival events, rsp_if returns exactly one
// response per event, csr_if writes the six node registers (always ready).
// Every transfer is a valid/ready handshake on a rising clock edge.
// An event that sends a packet goes from its transfer to rsp valid
// through two passes of the shared 8-step divider (destination column,
// then row); an event that sends nothing skips the divider.
// One event is in flight at a time, so a new event is not taken before the
// previous one has reached the output register; the next event is taken
// while the previous response still waits in the output register.
// After reset and after the last csr write, req ready stays low while
// three divider passes derive this node's row and column and the root's
// column; a write inside that window adds one more pass of all three. Reset
// restores the register defaults and clears the gather counters. A stalled
// receiver holds rsp valid and payload; the following event is processed
// but waits until the held response is taken.
// ----------------------------------------------------------------------------
module torus_gather_node_unit (
   input  wire logic clock,
   input  wire logic reset,
   tgn_req_if.sink   req_if,
   tgn_rsp_if.source rsp_if,
   tgn_csr_if.sink   csr_if
);
   import tgn_pkg::*;

   cmd_type    cmd;
   status_type status;

   tgn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tgn_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if),
      .cmd    (cmd),
      .status (status)
   );

endmodule

`default_nettype wire
